// ===== rtl/core/grid_rectangle_packer_macros.svh =====
// Assertion macros shared by the packer checker
`ifndef GRID_RECTANGLE_PACKER_MACROS_SVH
`define GRID_RECTANGLE_PACKER_MACROS_SVH
// same-cycle implication, checked outside reset
`define GRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, checked outside reset
`define GRP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/core/grp_pkg.sv =====
// Package for the grid rectangle packer: sizes, states and shared types
package grp_pkg;
  localparam int MAX_DIM = 64;
  localparam int ROW_W   = MAX_DIM;
  localparam int ADDR_W  = $clog2(MAX_DIM);
  localparam int DIM_W   = 7;
  localparam int EXT_W   = DIM_W + 1;
  localparam int AREA_W  = 2 * EXT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_ACC,
    ST_COL,
    ST_FIN,
    ST_MRD,
    ST_MWR,
    ST_DONE
  } grp_state_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ROW_W-1:0]  wr_data;
  } grp_mem_req_t;

  typedef struct packed {
    logic [DIM_W-1:0] place_x;
    logic [DIM_W-1:0] place_y;
    logic [DIM_W-1:0] grid_w;
    logic [DIM_W-1:0] grid_h;
    logic             overflow;
  } grp_res_t;
endpackage

// ===== rtl/core/grp_mem.sv =====
// Occupancy row memory with per-row valid bits; unwritten rows read as free
module grp_mem import grp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  grp_mem_req_t     req,
  output logic [ROW_W-1:0] rd_data
);
  logic [ROW_W-1:0] mem [MAX_DIM];
  logic [MAX_DIM-1:0] vld_r;
  logic [ROW_W-1:0] rd_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_r : '0;
endmodule

// ===== rtl/core/grp_ctrl.sv =====
// Placement sequencer: scans origins against memory rows, then marks cells
module grp_ctrl import grp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [DIM_W-1:0] in_w,
  input  logic [DIM_W-1:0] in_h,
  output grp_mem_req_t     mem_req,
  input  logic [ROW_W-1:0] rd_data,
  output grp_res_t         res,
  output logic             res_valid,
  input  logic             res_take
);
  grp_state_t state_r, state_nxt;
  logic [DIM_W-1:0]  w_r, w_nxt, h_r, h_nxt;
  logic [DIM_W-1:0]  gw_r, gw_nxt, gh_r, gh_nxt;
  logic [DIM_W-1:0]  ox_r, ox_nxt, oy_r, oy_nxt;
  logic [DIM_W-1:0]  bx_r, bx_nxt, by_r, by_nxt;
  logic [EXT_W-1:0]  bw_r, bw_nxt, bh_r, bh_nxt;
  logic [EXT_W-1:0]  ry_r, ry_nxt;
  logic [ROW_W-1:0]  acc_r, acc_nxt;
  logic [AREA_W-1:0] best_r, best_nxt;
  logic              found_r, found_nxt, ovf_r, ovf_nxt;

  logic [EXT_W-1:0]  ox_end, oy_end, nw, nh, row_end, mark_end, sq_w;
  logic [AREA_W-1:0] area;
  logic [ROW_W-1:0]  wmask;
  logic              spot_ok, better, ovf_now;

  always_comb begin
    ox_end   = {1'b0, ox_r} + {1'b0, w_r};
    oy_end   = {1'b0, oy_r} + {1'b0, h_r};
    nw       = (ox_end > {1'b0, gw_r}) ? ox_end : {1'b0, gw_r};
    nh       = (oy_end > {1'b0, gh_r}) ? oy_end : {1'b0, gh_r};
    area     = AREA_W'(nw) * AREA_W'(nh);
    row_end  = (oy_end > {1'b0, gh_r}) ? {1'b0, gh_r} : oy_end;
    mark_end = ({1'b0, by_r} + {1'b0, h_r} > EXT_W'(MAX_DIM)) ?
               EXT_W'(MAX_DIM) : {1'b0, by_r} + {1'b0, h_r};
    wmask    = (w_r >= DIM_W'(ROW_W)) ? '1 : ((ROW_W'(1) << w_r) - ROW_W'(1));
    spot_ok  = ((acc_r >> ox_r) & wmask) == '0;
    better   = !found_r || (area < best_r);
    sq_w     = (bh_r > bw_r) ? bh_r : bw_r;
    ovf_now  = (sq_w > EXT_W'(MAX_DIM)) || (bh_r > EXT_W'(MAX_DIM));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_ROW;
      ST_ROW:  state_nxt = (ry_r < row_end) ? ST_ACC : ST_COL;
      ST_ACC:  state_nxt = ST_ROW;
      ST_COL: begin
        if (ox_r == gw_r) state_nxt = (oy_r == gh_r) ? ST_FIN : ST_ROW;
      end
      ST_FIN:  state_nxt = ovf_now ? ST_DONE : ST_MRD;
      ST_MRD:  state_nxt = (ry_r < mark_end) ? ST_MWR : ST_DONE;
      ST_MWR:  state_nxt = ST_MRD;
      ST_DONE: if (res_take) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    w_nxt = w_r;   h_nxt = h_r;   gw_nxt = gw_r; gh_nxt = gh_r;
    ox_nxt = ox_r; oy_nxt = oy_r; bx_nxt = bx_r; by_nxt = by_r;
    bw_nxt = bw_r; bh_nxt = bh_r; ry_nxt = ry_r; acc_nxt = acc_r;
    best_nxt = best_r; found_nxt = found_r; ovf_nxt = ovf_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    mem_req   = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          w_nxt = in_w; h_nxt = in_h;
          oy_nxt = '0; ry_nxt = '0; acc_nxt = '0; found_nxt = 1'b0;
        end
      end
      ST_ROW: begin
        mem_req.rd_en   = ry_r < row_end;
        mem_req.rd_addr = ry_r[ADDR_W-1:0];
        ox_nxt = '0;
      end
      ST_ACC: begin
        acc_nxt = acc_r | rd_data;
        ry_nxt  = ry_r + EXT_W'(1);
      end
      ST_COL: begin
        if (better && spot_ok) begin
          found_nxt = 1'b1; best_nxt = area;
          bx_nxt = ox_r; by_nxt = oy_r; bw_nxt = nw; bh_nxt = nh;
        end
        if (ox_r == gw_r) begin
          oy_nxt  = oy_r + DIM_W'(1);
          ry_nxt  = {1'b0, oy_r} + EXT_W'(1);
          acc_nxt = '0;
        end else begin
          ox_nxt = ox_r + DIM_W'(1);
        end
      end
      ST_FIN: begin
        ovf_nxt = ovf_now;
        if (!ovf_now) begin
          gw_nxt = sq_w[DIM_W-1:0];
          gh_nxt = bh_r[DIM_W-1:0];
          ry_nxt = {1'b0, by_r};
        end
      end
      ST_MRD: begin
        mem_req.rd_en   = ry_r < mark_end;
        mem_req.rd_addr = ry_r[ADDR_W-1:0];
      end
      ST_MWR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = ry_r[ADDR_W-1:0];
        mem_req.wr_data = rd_data | (wmask << bx_r);
        ry_nxt = ry_r + EXT_W'(1);
      end
      ST_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    res.overflow = ovf_r;
    res.place_x  = ovf_r ? '0 : bx_r;
    res.place_y  = ovf_r ? '0 : by_r;
    res.grid_w   = ovf_r ? '0 : gw_r;
    res.grid_h   = ovf_r ? '0 : gh_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      gw_r    <= '0;
      gh_r    <= '0;
      found_r <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      gw_r    <= gw_nxt;
      gh_r    <= gh_nxt;
      found_r <= found_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;   h_r <= h_nxt;   ox_r <= ox_nxt; oy_r <= oy_nxt;
    bx_r <= bx_nxt; by_r <= by_nxt; bw_r <= bw_nxt; bh_r <= bh_nxt;
    ry_r <= ry_nxt; acc_r <= acc_nxt; best_r <= best_nxt;
  end
endmodule

// ===== rtl/core/grid_rectangle_packer.sv =====
// Grid rectangle packer top level
// Usage: send a rectangle size on in_req_width / in_req_height with
// in_valid/in_ready. One result word comes back on the out_ channel per
// request: chosen origin, grid size after placement, and an overflow flag
// (all other fields zero) when the grid would pass 64 cells on a side.
// Sequence: for origin row oy the block reads occupancy rows oy up to
// min(oy+h,gh)-1, then checks each candidate column (gw + 1 of them);
// marking reads and rewrites each covered row. The scan speed is set by
// the single-port row memory and the one-column-per-cycle origin check.
// One request is in work at a time.
// Reset: grid size goes to zero and every row of the occupancy memory
// reads as free at once (per-row valid bits); no clearing pass.
// Stall: a finished word sits in the output register; the next request is
// accepted meanwhile, and its result waits until that register frees.
module grid_rectangle_packer import grp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [DIM_W-1:0] in_req_width,
  input  logic [DIM_W-1:0] in_req_height,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [DIM_W-1:0] out_place_x,
  output logic [DIM_W-1:0] out_place_y,
  output logic [DIM_W-1:0] out_new_grid_width,
  output logic [DIM_W-1:0] out_new_grid_height,
  output logic             out_overflow
);
  grp_mem_req_t     mem_req;
  logic [ROW_W-1:0] rd_data;
  grp_res_t         res, res_r;
  logic             res_valid, res_take, out_valid_r;

  grp_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  grp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_w      (in_req_width),
    .in_h      (in_req_height),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .res       (res),
    .res_valid (res_valid),
    .res_take  (res_take)
  );

  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_place_x         = res_r.place_x;
  assign out_place_y         = res_r.place_y;
  assign out_new_grid_width  = res_r.grid_w;
  assign out_new_grid_height = res_r.grid_h;
  assign out_overflow        = res_r.overflow;
endmodule

// ===== rtl/core/grp_checker.sv =====
// Port-level checker for the grid rectangle packer, bound to the top level
`include "grid_rectangle_packer_macros.svh"
module grp_checker import grp_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [DIM_W-1:0] out_place_x,
  input logic [DIM_W-1:0] out_new_grid_width,
  input logic [DIM_W-1:0] out_new_grid_height,
  input logic             out_overflow
);
  `GRP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_place_x), "out word changed while stalled")
  `GRP_ASSERT_IMP(a_ovf_zero, out_valid && out_overflow, out_place_x == '0 && out_new_grid_width == '0, "overflow word not cleared")
  `GRP_ASSERT_IMP(a_square, out_valid && !out_overflow, out_new_grid_width >= out_new_grid_height, "grid wider side lost")
  `GRP_ASSERT_IMP(a_limit, out_valid && !out_overflow, out_new_grid_width <= DIM_W'(MAX_DIM), "grid past limit")
endmodule

bind grid_rectangle_packer grp_checker u_grp_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_place_x         (out_place_x),
  .out_new_grid_width  (out_new_grid_width),
  .out_new_grid_height (out_new_grid_height),
  .out_overflow        (out_overflow)
);
